FILE: hw/rtl/combinadic_unrank_macros.svh
// Assertion macros used by combinadic_unrank.sv.
`ifndef COMBINADIC_UNRANK_MACROS_SVH
`define COMBINADIC_UNRANK_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge out of reset
`define CU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("combinadic_unrank: same-cycle check failed");

// Next-cycle implication
`define CU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("combinadic_unrank: next-cycle check failed");

`else

`define CU_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/cu_pkg.sv
`timescale 1ns / 1ps

package cu_pkg;

  // Field widths
  localparam int RANK_W = 31;
  localparam int POS_W  = 4;

  // Element search width: C(65537,2) already exceeds any 31-bit rank
  localparam int SEARCH_W = 17;

  // Shared multiplier operand width
  localparam int MUL_W = 32;

  // rank * k for k up to the largest tuple length
  localparam int LIM_W = RANK_W + POS_W;

  localparam int MAX_TUPLE_DEF = 8;

  // Exact division by k: k = 2^s * m, m odd; divide = shift by s, then
  // multiply by the inverse of m modulo 2^32 (valid while the quotient fits).
  function automatic logic [1:0] exact_shift(input logic [POS_W-1:0] k);
    logic [1:0] s;
    unique case (k)
      4'd2, 4'd6, 4'd10: s = 2'd1;
      4'd4, 4'd12:       s = 2'd2;
      4'd8:              s = 2'd3;
      default:           s = 2'd0;
    endcase
    return s;
  endfunction

  function automatic logic [MUL_W-1:0] odd_inverse(input logic [POS_W-1:0] k);
    logic [MUL_W-1:0] inv;
    unique case (k)
      4'd3, 4'd6, 4'd12: inv = 32'hAAAA_AAAB;
      4'd5, 4'd10:       inv = 32'hCCCC_CCCD;
      4'd7:              inv = 32'hB6DB_6DB7;
      4'd9:              inv = 32'h38E3_8E39;
      4'd11:             inv = 32'hBA2E_8BA3;
      default:           inv = 32'h0000_0001;
    endcase
    return inv;
  endfunction

endpackage

FILE: hw/rtl/cu_mult.sv
`timescale 1ns / 1ps

module cu_mult (
  input  logic                         clk,
  input  logic [cu_pkg::MUL_W-1:0]     a_i,
  input  logic [cu_pkg::MUL_W-1:0]     b_i,
  output logic [2*cu_pkg::MUL_W-1:0]   p_o
);
  import cu_pkg::*;

  logic [2*MUL_W-1:0] prod_r;
  logic [2*MUL_W-1:0] prod_nxt;

  // Full product of the two operands
  assign prod_nxt = {{MUL_W{1'b0}}, a_i} * {{MUL_W{1'b0}}, b_i};

  // Register the product
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign p_o = prod_r;

endmodule

FILE: hw/rtl/combinadic_unrank.sv
`timescale 1ns / 1ps

// Combinadic unranking. A rank word is taken when start is high and busy is
// low; the block then emits one result word per position, from the tuple
// length down to 1, each on out_* for exactly one cycle with out_valid high.
// The receiver cannot stall: every strobed word must be captured. Position 1
// passes through the setup and emit states only. A position i >= 2
// binary-searches a 17-bit element: each probe builds the binomial one
// factor at a time through the single registered 32x32 multiplier, with a
// multiply, divide and check state per factor, and gives up early once the
// partial binomial passes the remaining rank. A tuple length of zero emits
// nothing; lengths above MAX_TUPLE saturate. tuple_len must be written
// through cfg_* while busy is low; the block itself does not enforce this.
module combinadic_unrank #(
  parameter int MAX_TUPLE = cu_pkg::MAX_TUPLE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // rank input
  input  logic                        start,
  output logic                        busy,
  input  logic [cu_pkg::RANK_W-1:0]   in_rank,
  // result output
  output logic                        out_valid,
  output logic [cu_pkg::POS_W-1:0]    out_position,
  output logic [cu_pkg::RANK_W-1:0]   out_element,
  output logic                        out_last,
  // configuration
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cu_pkg::POS_W-1:0]    cfg_tuple_len
);
  import cu_pkg::*;

  `include "combinadic_unrank_macros.svh"

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SETUP = 7'b0000010,
    ST_PROBE = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_CHK   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_t;

  // control state
  state_t              state_r, state_nxt;
  logic [POS_W-1:0]    len_r, len_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;

  // datapath
  logic [RANK_W-1:0]   rem_r, rem_nxt;
  logic [SEARCH_W-1:0] c_r, c_nxt;
  logic [SEARCH_W-1:0] trial_r, trial_nxt;
  logic [SEARCH_W-1:0] base_r, base_nxt;
  logic [SEARCH_W-1:0] mask_r, mask_nxt;
  logic [RANK_W-1:0]   v_r, v_nxt;
  logic [POS_W-1:0]    k_r, k_nxt;
  logic [LIM_W-1:0]    lim_r, lim_nxt;
  logic                over_r, over_nxt;
  logic [RANK_W-1:0]   best_r, best_nxt;
  logic [RANK_W-1:0]   elem_r, elem_nxt;

  // shared multiplier
  logic [MUL_W-1:0]    mul_a;
  logic [MUL_W-1:0]    mul_b;
  logic [2*MUL_W-1:0]  mul_p;

  logic [SEARCH_W-1:0] trial;
  logic [2*MUL_W-1:0]  shifted;

  cu_mult u_mult (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  assign trial   = c_r | mask_r;
  assign shifted = mul_p >> exact_shift(k_r);

  // Sequencer and datapath next state
  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    rem_nxt   = rem_r;
    c_nxt     = c_r;
    trial_nxt = trial_r;
    base_nxt  = base_r;
    mask_nxt  = mask_r;
    v_nxt     = v_r;
    k_nxt     = k_r;
    lim_nxt   = lim_r;
    over_nxt  = over_r;
    best_nxt  = best_r;
    elem_nxt  = elem_r;
    mul_a     = MUL_W'(v_r);
    mul_b     = MUL_W'(base_r + SEARCH_W'(k_r));

    // take a new tuple length
    if (cfg_valid) begin
      len_nxt = cfg_tuple_len;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start && len_r != '0) begin
          pos_nxt   = (len_r > POS_W'(MAX_TUPLE)) ? POS_W'(MAX_TUPLE) : len_r;
          rem_nxt   = in_rank;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        // position 1: the element is the remaining rank itself
        if (pos_r == POS_W'(1)) begin
          elem_nxt  = rem_r;
          best_nxt  = rem_r;
          state_nxt = ST_EMIT;
        end else begin
          c_nxt     = '0;
          best_nxt  = '0;
          mask_nxt  = {1'b1, {(SEARCH_W-1){1'b0}}};
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (mask_r == '0) begin
          elem_nxt  = RANK_W'(c_r);
          state_nxt = ST_EMIT;
        end else if (trial < SEARCH_W'(pos_r)) begin
          // binomial is zero below the position: always fits
          c_nxt    = trial;
          best_nxt = '0;
          mask_nxt = mask_r >> 1;
        end else begin
          trial_nxt = trial;
          base_nxt  = trial - SEARCH_W'(pos_r);
          v_nxt     = RANK_W'(1);
          k_nxt     = POS_W'(1);
          lim_nxt   = LIM_W'(rem_r);
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        // partial binomial times the next factor
        mul_a     = MUL_W'(v_r);
        mul_b     = MUL_W'(base_r + SEARCH_W'(k_r));
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // exact divide by k; flag a product past rem * k
        mul_a     = shifted[MUL_W-1:0];
        mul_b     = odd_inverse(k_r);
        over_nxt  = mul_p > (2*MUL_W)'(lim_r);
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (over_r) begin
          // drop this probe bit
          mask_nxt  = mask_r >> 1;
          state_nxt = ST_PROBE;
        end else if (k_r == pos_r) begin
          c_nxt     = trial_r;
          best_nxt  = mul_p[RANK_W-1:0];
          mask_nxt  = mask_r >> 1;
          state_nxt = ST_PROBE;
        end else begin
          v_nxt     = mul_p[RANK_W-1:0];
          k_nxt     = k_r + POS_W'(1);
          lim_nxt   = lim_r + LIM_W'(rem_r);
          state_nxt = ST_MUL;
        end
      end
      ST_EMIT: begin
        // subtract the binomial and advance to the next position
        rem_nxt   = rem_r - best_r;
        pos_nxt   = pos_r - POS_W'(1);
        state_nxt = (pos_r == POS_W'(1)) ? ST_IDLE : ST_SETUP;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= POS_W'(2);
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    c_r     <= c_nxt;
    trial_r <= trial_nxt;
    base_r  <= base_nxt;
    mask_r  <= mask_nxt;
    v_r     <= v_nxt;
    k_r     <= k_nxt;
    lim_r   <= lim_nxt;
    over_r  <= over_nxt;
    best_r  <= best_nxt;
    elem_r  <= elem_nxt;
  end

  assign busy         = (state_r != ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign out_valid    = (state_r == ST_EMIT);
  assign out_position = pos_r;
  assign out_element  = elem_r;
  assign out_last     = (pos_r == POS_W'(1));

  // Checks
  `CU_ASSERT_IMPL(a_emit_pos, clk, rst_n, out_valid,
                  out_position != '0 && out_position <= POS_W'(MAX_TUPLE))
  `CU_ASSERT_NEXT(a_last_idle, clk, rst_n, out_valid && out_last, !busy)
  `CU_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy && len_r != '0, busy)
  `CU_ASSERT_IMPL(a_factor_range, clk, rst_n,
                  state_r == ST_MUL || state_r == ST_DIV || state_r == ST_CHK,
                  k_r != '0 && k_r <= pos_r && pos_r > POS_W'(1))
  `CU_ASSERT_NEXT(a_emit_step, clk, rst_n, out_valid && !out_last,
                  pos_r == $past(pos_r) - POS_W'(1))

endmodule
